>>> sv/dithered_rect_fill_core_macros.svh
// Assertion macros shared by the dithered rectangle fill core.
// Each macro expects clk_i and rst_ni in the scope where it is used.
`ifndef DITHERED_RECT_FILL_CORE_MACROS_SVH
`define DITHERED_RECT_FILL_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DRFC_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define DRFC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/drfc_pkg.sv
// Shared types and constants for the dithered rectangle fill core.
// Used by the controller, the datapath and the top level.
`timescale 1ns / 1ps

package drfc_pkg;

  typedef enum logic [1:0] {
    OP_FILL  = 2'd0,
    OP_READ  = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NONE  = 2'd3
  } drfc_op_e;

  localparam logic [1:0] REG_ROW_BYTES  = 2'd0;
  localparam logic [1:0] REG_BAND_ROWS  = 2'd1;
  localparam logic [1:0] REG_BAND_FIRST = 2'd2;

  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned LINE_W     = 17;
  localparam int unsigned BASE_W     = 24;
  localparam int unsigned WIDE_W     = 25;
  localparam int unsigned K_W        = 12;
  localparam int unsigned LEVEL_W    = 5;

  // Level is density * 15 / 100, done as a multiply by 2^19 / 100 rounded up.
  localparam logic [12:0] LEVEL_RECIP = 13'd5243;
  localparam int unsigned LEVEL_SHIFT = 19;

  localparam logic [3:0] BAYER [16] = '{
    4'd0, 4'd8, 4'd2, 4'd10, 4'd12, 4'd4, 4'd14, 4'd6,
    4'd3, 4'd11, 4'd1, 4'd9, 4'd15, 4'd7, 4'd13, 4'd5
  };

  typedef struct packed {
    logic load;
    logic setup;
    logic base_calc;
    logic line_init;
    logic next_line;
    logic rd_fill;
    logic wr_fill;
    logic k_inc;
    logic rd_cmd;
    logic rd_capture;
    logic clr_step;
    logic out_load;
  } drfc_cmd_t;

  typedef struct packed {
    drfc_op_e op;
    logic     lines_done;
    logic     addr_oob;
    logic     byte_last;
    logic     clr_last;
  } drfc_status_t;

endpackage

>>> sv/drfc_ctrl.sv
// Controller state machine of the dithered rectangle fill core.
// Depends on drfc_pkg and the shared assertion macros.
`timescale 1ns / 1ps
`include "dithered_rect_fill_core_macros.svh"

module drfc_ctrl
  import drfc_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_ready_o,
  output logic         out_valid_o,
  input  logic         out_ready_i,
  input  drfc_status_t sts_i,
  output drfc_cmd_t    cmd_o
);

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_SETUP,
    ST_BASE,
    ST_LINE,
    ST_RD,
    ST_WR,
    ST_RDCMD,
    ST_RDOUT,
    ST_CLEAR,
    ST_DONE
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    unique case (state_q)
      ST_INIT: begin
        cmd_o.clr_step = 1'b1;
        if (sts_i.clr_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_SETUP;
        end
      end
      ST_SETUP: begin
        cmd_o.setup = 1'b1;
        unique case (sts_i.op)
          OP_FILL:  state_d = ST_BASE;
          OP_READ:  state_d = ST_RDCMD;
          OP_CLEAR: state_d = ST_CLEAR;
          OP_NONE:  state_d = ST_DONE;
        endcase
      end
      ST_BASE: begin
        cmd_o.base_calc = 1'b1;
        state_d         = ST_LINE;
      end
      ST_LINE: begin
        if (sts_i.lines_done) begin
          state_d = ST_DONE;
        end else begin
          cmd_o.line_init = 1'b1;
          state_d         = ST_RD;
        end
      end
      ST_RD: begin
        if (sts_i.addr_oob) begin
          cmd_o.next_line = 1'b1;
          state_d         = ST_LINE;
        end else begin
          cmd_o.rd_fill = 1'b1;
          state_d       = ST_WR;
        end
      end
      ST_WR: begin
        cmd_o.wr_fill = 1'b1;
        if (sts_i.byte_last) begin
          cmd_o.next_line = 1'b1;
          state_d         = ST_LINE;
        end else begin
          cmd_o.k_inc = 1'b1;
          state_d     = ST_RD;
        end
      end
      ST_RDCMD: begin
        cmd_o.rd_cmd = 1'b1;
        state_d      = ST_RDOUT;
      end
      ST_RDOUT: begin
        cmd_o.rd_capture = 1'b1;
        state_d          = ST_DONE;
      end
      ST_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (sts_i.clr_last) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cmd_o.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

  `DRFC_ASSERT_NEXT(a_busy_after_accept, in_valid_i && in_ready_o, !in_ready_o, "input accepted while busy")
  `DRFC_ASSERT_SAME(a_out_load_free, cmd_o.out_load, !out_valid_q || out_ready_i, "result overwrote a pending transfer")
  `DRFC_ASSERT_NEXT(a_write_follows_read, cmd_o.rd_fill, cmd_o.wr_fill, "fill read not followed by its write")
  `DRFC_ASSERT_SAME(a_clear_exclusive, cmd_o.clr_step, !cmd_o.wr_fill && !cmd_o.rd_fill && !in_ready_o, "clear sweep overlaps other work")

endmodule

>>> sv/drfc_datapath.sv
// Datapath of the dithered rectangle fill core: registers, band memory and dither logic.
// Depends on drfc_pkg and is driven by drfc_ctrl.
`timescale 1ns / 1ps

module drfc_datapath
  import drfc_pkg::*;
#(
  parameter int unsigned BUF_BYTES = 65536
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  drfc_cmd_t             cmd_i,
  output drfc_status_t          sts_o,
  input  logic                  cfg_we_i,
  input  logic [1:0]            cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic [1:0]            in_cmd_i,
  input  logic [13:0]           x_pos_i,
  input  logic [15:0]           y_pos_i,
  input  logic [13:0]           width_i,
  input  logic [15:0]           height_i,
  input  logic [6:0]            density_i,
  input  logic [15:0]           address_i,
  output logic [7:0]            data_o,
  output logic                  was_read_o
);

  localparam int unsigned AW = $clog2(BUF_BYTES);
  localparam logic [WIDE_W-1:0] BUF_LIMIT = WIDE_W'(BUF_BYTES);
  localparam logic [AW-1:0] CLR_LAST = AW'(BUF_BYTES - 1);

  logic [10:0] row_bytes_q;
  logic [12:0] band_rows_q;
  logic [15:0] band_first_q;

  drfc_op_e    op_q;
  logic [13:0] x0_q;
  logic [15:0] y0_q;
  logic [13:0] w_q;
  logic [15:0] h_q;
  logic [6:0]  dens_q;
  logic [15:0] addr_q;

  logic [LEVEL_W-1:0] level_q;
  logic [LINE_W-1:0]  line_q;
  logic [LINE_W-1:0]  line_end_q;
  logic [K_W-1:0]     kf_q;
  logic [K_W-1:0]     kl_q;
  logic [2:0]         xl_q;
  logic               w_zero_q;
  logic [BASE_W-1:0]  base_q;
  logic [K_W-1:0]     k_q;
  logic [AW-1:0]      wr_addr_q;
  logic [7:0]         mask_q;
  logic [7:0]         rdata_q;
  logic [AW-1:0]      clr_idx_q;
  logic [7:0]         res_data_q;
  logic               res_read_q;
  logic [7:0]         data_q;
  logic               was_read_q;

  logic [7:0] band_mem_q [BUF_BYTES];

  logic [LINE_W-1:0] y_end;
  logic [LINE_W-1:0] band_end;
  logic [14:0]       x_last;
  logic [10:0]       dens15;
  logic [23:0]       level_prod;
  logic [LINE_W-1:0] row_off;
  logic [WIDE_W-1:0] fill_addr;
  logic [WIDE_W-1:0] read_addr;
  logic [AW-1:0]     rd_addr;
  logic [1:0]        dy;
  logic [7:0]        dither_pat;
  logic [7:0]        left_mask;
  logic [7:0]        right_mask;

  assign y_end      = LINE_W'(y0_q) + LINE_W'(h_q);
  assign band_end   = LINE_W'(band_first_q) + LINE_W'(band_rows_q);
  assign x_last     = 15'(x0_q) + 15'(w_q) - 15'd1;
  assign dens15     = {dens_q, 4'b0000} - 11'(dens_q);
  assign level_prod = 24'(dens15) * 24'(LEVEL_RECIP);
  assign row_off    = line_q - LINE_W'(band_first_q);
  assign fill_addr  = WIDE_W'(base_q) + WIDE_W'(k_q);
  assign read_addr  = WIDE_W'(addr_q);
  assign rd_addr    = cmd_i.rd_cmd ? read_addr[AW-1:0] : fill_addr[AW-1:0];
  assign dy         = line_q[1:0] - y0_q[1:0];

  always_comb begin
    logic [1:0] phase;
    for (int b = 0; b < 8; b++) begin
      phase          = 2'(b) - x0_q[1:0];
      dither_pat[7-b] = LEVEL_W'(BAYER[{dy, phase}]) <= level_q;
    end
  end

  assign left_mask  = (k_q == kf_q) ? (8'hFF >> x0_q[2:0]) : 8'hFF;
  assign right_mask = (k_q == kl_q) ? (8'hFF << (3'd7 - xl_q)) : 8'hFF;

  assign sts_o.op         = op_q;
  assign sts_o.lines_done = w_zero_q || (line_q >= line_end_q)
                            || (WIDE_W'(base_q) >= BUF_LIMIT);
  assign sts_o.addr_oob   = fill_addr >= BUF_LIMIT;
  assign sts_o.byte_last  = k_q == kl_q;
  assign sts_o.clr_last   = clr_idx_q == CLR_LAST;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_bytes_q  <= 11'd64;
      band_rows_q  <= 13'd1;
      band_first_q <= 16'd0;
      clr_idx_q    <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          REG_ROW_BYTES:  row_bytes_q  <= cfg_data_i[10:0];
          REG_BAND_ROWS:  band_rows_q  <= cfg_data_i[12:0];
          REG_BAND_FIRST: band_first_q <= cfg_data_i[15:0];
          default: ;
        endcase
      end
      if (cmd_i.clr_step) begin
        clr_idx_q <= sts_o.clr_last ? '0 : clr_idx_q + AW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q   <= drfc_op_e'(in_cmd_i);
      x0_q   <= x_pos_i;
      y0_q   <= y_pos_i;
      w_q    <= width_i;
      h_q    <= height_i;
      dens_q <= density_i;
      addr_q <= address_i;
    end
    if (cmd_i.setup) begin
      level_q    <= level_prod[LEVEL_SHIFT +: LEVEL_W];
      line_q     <= (y0_q > band_first_q) ? LINE_W'(y0_q) : LINE_W'(band_first_q);
      line_end_q <= (y_end < band_end) ? y_end : band_end;
      kf_q       <= K_W'(x0_q[13:3]);
      kl_q       <= x_last[14:3];
      xl_q       <= x_last[2:0];
      w_zero_q   <= (w_q == 14'd0);
      res_data_q <= 8'd0;
      res_read_q <= 1'b0;
    end
    if (cmd_i.base_calc) begin
      base_q <= BASE_W'(row_off[12:0]) * BASE_W'(row_bytes_q);
    end else if (cmd_i.next_line) begin
      base_q <= base_q + BASE_W'(row_bytes_q);
    end
    if (cmd_i.next_line) begin
      line_q <= line_q + LINE_W'(1);
    end
    if (cmd_i.line_init) begin
      k_q <= kf_q;
    end else if (cmd_i.k_inc) begin
      k_q <= k_q + K_W'(1);
    end
    if (cmd_i.rd_fill) begin
      wr_addr_q <= fill_addr[AW-1:0];
      mask_q    <= dither_pat & left_mask & right_mask;
    end
    if (cmd_i.rd_capture) begin
      res_data_q <= (read_addr < BUF_LIMIT) ? rdata_q : 8'd0;
      res_read_q <= 1'b1;
    end
    if (cmd_i.out_load) begin
      data_q     <= res_data_q;
      was_read_q <= res_read_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.clr_step) begin
      band_mem_q[clr_idx_q] <= 8'd0;
    end else if (cmd_i.wr_fill) begin
      band_mem_q[wr_addr_q] <= rdata_q | mask_q;
    end
    if (cmd_i.rd_fill || cmd_i.rd_cmd) begin
      rdata_q <= band_mem_q[rd_addr];
    end
  end

  assign data_o     = data_q;
  assign was_read_o = was_read_q;

endmodule

>>> sv/dithered_rect_fill_core.sv
// Fill: after setup and base steps, each band row drawn takes a line step plus a read and a
// write step per byte touched, and a row cut short at the buffer end ends with an out-of-range
// step; each byte is a read-modify-write of the band memory. Clear: one byte zeroed per cycle.
// One item is worked on at a time; the next input transfer can be taken in the same cycle
// that the result is first offered. After reset the band memory is swept to zero with
// in_ready_o low; configuration writes are taken at any time.
`timescale 1ns / 1ps

module dithered_rect_fill_core
  import drfc_pkg::*;
#(
  parameter int unsigned BUF_BYTES = 65536
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [1:0]            cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [1:0]            cmd_i,
  input  logic [13:0]           x_pos_i,
  input  logic [15:0]           y_pos_i,
  input  logic [13:0]           width_i,
  input  logic [15:0]           height_i,
  input  logic [6:0]            density_i,
  input  logic [15:0]           address_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [7:0]            data_o,
  output logic                  was_read_o
);

  drfc_cmd_t    cmd;
  drfc_status_t sts;

  assign cfg_ready_o = 1'b1;

  drfc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  drfc_datapath #(
    .BUF_BYTES (BUF_BYTES)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .cfg_we_i    (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_cmd_i    (cmd_i),
    .x_pos_i     (x_pos_i),
    .y_pos_i     (y_pos_i),
    .width_i     (width_i),
    .height_i    (height_i),
    .density_i   (density_i),
    .address_i   (address_i),
    .data_o      (data_o),
    .was_read_o  (was_read_o)
  );

endmodule

>>> test/testbench.sv
// Self-checking testbench for dithered_rect_fill_core: directed and random fill, read,
// clear and idle commands under several band settings, checked against a local bitmap.
// Depends on drfc_pkg and the core RTL only.
`timescale 1ns / 1ps

module testbench;
  import drfc_pkg::*;

  localparam int BUF_SIZE = 65536;
  localparam int CYCLE_LIMIT = 5_000_000;
  localparam int RX_HOLD_CYCLES = 600;
  localparam logic [1:0] REG_UNUSED = 2'd3;
  localparam bit [3:0] DITHER_RANK [16] = '{0, 8, 2, 10, 12, 4, 14, 6,
                                            3, 11, 1, 9, 15, 7, 13, 5};

  typedef struct {
    drfc_op_e    op;
    logic [13:0] x;
    logic [15:0] y;
    logic [13:0] w;
    logic [15:0] h;
    logic [6:0]  dens;
    logic [15:0] addr;
  } draw_cmd_t;

  typedef struct {
    logic [7:0] data;
    logic       was_read;
  } band_result_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [1:0]            cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  logic                  in_valid_i = 1'b0;
  logic                  in_ready_o;
  logic [1:0]            cmd_i = '0;
  logic [13:0]           x_pos_i = '0;
  logic [15:0]           y_pos_i = '0;
  logic [13:0]           width_i = '0;
  logic [15:0]           height_i = '0;
  logic [6:0]            density_i = '0;
  logic [15:0]           address_i = '0;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  logic [7:0]            data_o;
  logic                  was_read_o;

  logic [10:0]  cfg_row_bytes = 11'd64;
  logic [12:0]  cfg_band_rows = 13'd1;
  logic [15:0]  cfg_band_first = 16'd0;
  bit [7:0]     band_image [BUF_SIZE];
  band_result_t expected_results [$];
  int unsigned  last_fill_addr = 0;

  int  cycle_count = 0;
  int  items_sent = 0;
  int  results_checked = 0;
  int  reads_checked = 0;
  int  reg_writes = 0;
  int  error_count = 0;
  bit  idle_enabled = 1'b1;
  int  rx_hold_seq = 0;
  int  rx_hold_seen = 0;
  int  rx_hold_left = 0;

  dithered_rect_fill_core uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .cmd_i       (cmd_i),
    .x_pos_i     (x_pos_i),
    .y_pos_i     (y_pos_i),
    .width_i     (width_i),
    .height_i    (height_i),
    .density_i   (density_i),
    .address_i   (address_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .data_o      (data_o),
    .was_read_o  (was_read_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, expected_results.size());
      $display("testbench: FAIL");
      $finish;
    end
  end

  // ORs the dithered rectangle into the local bitmap, clipped to the band and buffer.
  function automatic void paint_rect(input draw_cmd_t c);
    int unsigned level;
    longint      line, line_end, band_end, base, col, addr;
    int unsigned dy, i;
    level = int'(c.dens) * 15 / 100;
    line = (c.y > cfg_band_first) ? c.y : cfg_band_first;
    last_fill_addr = (line - cfg_band_first) * cfg_row_bytes + (c.x >> 3);
    line_end = longint'(c.y) + longint'(c.h);
    band_end = longint'(cfg_band_first) + longint'(cfg_band_rows);
    if (line_end > band_end) line_end = band_end;
    for (; line < line_end; line++) begin
      base = (line - cfg_band_first) * cfg_row_bytes;
      if (base >= BUF_SIZE) break;
      dy = (line - c.y) & 3;
      for (i = 0; i < c.w; i++) begin
        col = c.x + i;
        addr = base + (col >> 3);
        if (addr >= BUF_SIZE) break;
        if (DITHER_RANK[(i & 3) + (dy << 2)] <= level)
          band_image[addr] |= 8'h80 >> (col & 7);
      end
    end
  endfunction

  function automatic void predict_command(input draw_cmd_t c);
    band_result_t res;
    res.data = 8'h00;
    res.was_read = 1'b0;
    case (c.op)
      OP_FILL: paint_rect(c);
      OP_READ: begin
        res.data = band_image[c.addr];
        res.was_read = 1'b1;
      end
      OP_CLEAR: foreach (band_image[k]) band_image[k] = 8'h00;
      default: ;
    endcase
    expected_results.push_back(res);
  endfunction

  // Mostly fills near the band and reads near the last fill, with a few wide, tall,
  // scattered and unused commands mixed in.
  function automatic draw_cmd_t random_command();
    draw_cmd_t   c;
    int unsigned pick, span, xspan;
    int          yy;
    pick = $urandom_range(99);
    span = (cfg_band_rows > 80) ? 80 : cfg_band_rows;
    xspan = int'(cfg_row_bytes) * 8 + 32;
    if (xspan > 16383) xspan = 16383;
    yy = int'(cfg_band_first) + int'($urandom_range(span + 8)) - 4;
    if (yy < 0) yy = 0;
    if (yy > 65535) yy = 65535;
    c.op = OP_FILL;
    c.x = $urandom_range(xspan);
    c.y = 16'(yy);
    c.w = $urandom_range(48);
    c.h = $urandom_range(10);
    c.dens = ($urandom_range(9) == 0) ? $urandom_range(127, 101) : $urandom_range(100);
    c.addr = last_fill_addr + $urandom_range(3) * cfg_row_bytes + $urandom_range(7);
    if (pick >= 95) begin
      c.x = $urandom;
      c.y = $urandom;
    end else if (pick >= 93) begin
      c.h = $urandom;
      c.w = $urandom_range(4);
    end else if (pick >= 91) begin
      c.w = $urandom;
      c.h = $urandom_range(1);
    end else if (pick >= 88) begin
      c.op = OP_NONE;
    end else if (pick >= 45) begin
      c.op = OP_READ;
      if ($urandom_range(3) == 0) c.addr = $urandom;
    end
    return c;
  endfunction

  task automatic send_command(input draw_cmd_t c);
    @(negedge clk_i);
    while (idle_enabled && $urandom_range(99) < 25) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    cmd_i <= c.op;
    x_pos_i <= c.x;
    y_pos_i <= c.y;
    width_i <= c.w;
    height_i <= c.h;
    density_i <= c.dens;
    address_i <= c.addr;
    in_valid_i <= 1'b1;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    predict_command(c);
    items_sent++;
  endtask

  task automatic send_fill(input int x, input int y, input int w, input int h, input int d);
    draw_cmd_t c;
    c.op = OP_FILL;
    c.x = x;
    c.y = y;
    c.w = w;
    c.h = h;
    c.dens = d;
    c.addr = '0;
    send_command(c);
  endtask

  task automatic send_plain(input drfc_op_e op, input int a);
    draw_cmd_t c;
    c = '{op: op, x: '0, y: '0, w: '0, h: '0, dens: '0, addr: a};
    send_command(c);
  endtask

  task automatic send_read(input int a);
    send_plain(OP_READ, a);
  endtask

  task automatic run_traffic(input int count);
    draw_cmd_t c;
    repeat (count) begin
      c = random_command();
      send_command(c);
    end
  endtask

  // Drops the input valid and waits until every expected result has been checked.
  task automatic settle_block();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] value);
    @(negedge clk_i);
    cfg_index_i <= idx;
    cfg_data_i <= value;
    cfg_valid_i <= 1'b1;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      REG_ROW_BYTES:  cfg_row_bytes = value[10:0];
      REG_BAND_ROWS:  cfg_band_rows = value[12:0];
      REG_BAND_FIRST: cfg_band_first = value;
      default: ;
    endcase
    reg_writes++;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic set_band(input int row_len, input int rows, input int first);
    settle_block();
    write_reg(REG_ROW_BYTES, row_len);
    write_reg(REG_BAND_ROWS, rows);
    write_reg(REG_BAND_FIRST, first);
  endtask

  always @(negedge clk_i) begin
    if (rx_hold_seen != rx_hold_seq) begin
      rx_hold_seen = rx_hold_seq;
      rx_hold_left = RX_HOLD_CYCLES;
    end
    if (rx_hold_left > 0) begin
      rx_hold_left--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= !(idle_enabled && $urandom_range(99) < 25);
    end
  end

  always @(posedge clk_i) begin
    band_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_results.size() == 0) begin
        $display("%0t: result with none expected: data %02h was_read %0b",
                 $time, data_o, was_read_o);
        error_count++;
      end else begin
        want = expected_results.pop_front();
        results_checked++;
        if (want.was_read) reads_checked++;
        if (data_o !== want.data) begin
          $display("%0t: data mismatch: expected %02h, actual %02h", $time, want.data, data_o);
          error_count++;
        end
        if (was_read_o !== want.was_read) begin
          $display("%0t: was_read mismatch: expected %0b, actual %0b",
                   $time, want.was_read, was_read_o);
          error_count++;
        end
      end
    end
  end

  task automatic test_reset_state();
    send_read(0);
    send_read(16'hFFFF);
  endtask

  task automatic test_directed_cases();
    set_band(16, 8, 4);
    send_fill(0, 4, 8, 4, 100);
    send_read(16);
    send_fill(16, 4, 8, 4, 0);
    send_read(2);
    send_fill(24, 4, 8, 4, 127);
    send_read(19);
    send_fill(32, 5, 8, 4, 50);
    send_read(20);
    send_fill(40, 4, 0, 4, 100);
    send_fill(40, 4, 8, 0, 100);
    send_fill(48, 0, 8, 6, 100);
    send_read(6);
    send_fill(56, 10, 8, 10, 100);
    send_read(119);
    send_fill(124, 6, 8, 1, 100);
    send_read(48);
    send_fill(16383, 11, 16383, 1, 100);
    send_read(2159);
    send_fill(0, 65535, 8, 1, 100);
    send_fill(0, 0, 3, 65535, 100);
    send_plain(OP_NONE, 0);
    send_plain(OP_CLEAR, 0);
    send_read(16);
  endtask

  task automatic test_output_backpressure();
    settle_block();
    idle_enabled = 1'b0;
    rx_hold_seq++;
    run_traffic(8);
    idle_enabled = 1'b1;
  endtask

  task automatic test_mid_band();
    set_band(40, 64, 100);
    run_traffic(250);
  endtask

  task automatic test_wide_rows();
    set_band(1024, 4096, 0);
    idle_enabled = 1'b0;
    run_traffic(220);
    idle_enabled = 1'b1;
  endtask

  task automatic test_narrow_rows();
    set_band(1, 4096, 61440);
    send_plain(OP_CLEAR, 0);
    run_traffic(200);
  endtask

  task automatic test_degenerate_band();
    set_band(40, 0, 100);
    run_traffic(40);
    set_band(0, 300, 200);
    run_traffic(160);
  endtask

  task automatic test_register_width();
    settle_block();
    send_plain(OP_CLEAR, 0);
    settle_block();
    write_reg(REG_ROW_BYTES, 16'hFFFF);
    write_reg(REG_BAND_ROWS, 16'hFFFF);
    write_reg(REG_BAND_FIRST, 16'hFFFF);
    write_reg(REG_UNUSED, 16'hFFFF);
    run_traffic(80);
    settle_block();
    write_reg(REG_BAND_FIRST, 16'h0000);
    run_traffic(80);
  endtask

  task automatic test_drained_bursts();
    repeat (6) begin
      run_traffic(10);
      settle_block();
    end
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_reset_state();
    test_directed_cases();
    test_output_backpressure();
    test_mid_band();
    test_wide_rows();
    test_narrow_rows();
    test_degenerate_band();
    test_register_width();
    test_drained_bursts();
    settle_block();
    repeat (50) @(posedge clk_i);
    if (expected_results.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, expected_results.size());
      error_count++;
    end
    $display("Covered %0d commands over %0d register writes; %0d results checked, %0d of them reads.",
             items_sent, reg_writes, results_checked, reads_checked);
    $display("Mismatches found: %0d.", error_count);
    if (error_count == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
